// ----- design/evad_pkg.sv -----
// ----------------------------------------------------------------------------
// evad_pkg
// shared types, constants and helper functions of the voice activity detector
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int WINDOW_FRAMES = 5;
  localparam int FRAME_SAMPLES = 256;
  localparam int SQRT_TAB_SIZE = 96;
  localparam int CNT_W         = $clog2(FRAME_SAMPLES + 1);
  localparam int VOTE_W        = $clog2(WINDOW_FRAMES + 1);
  localparam int DIV_W         = 48;
  localparam int DIV_CNT_W     = $clog2(DIV_W);
  localparam int RMS_W         = 24;

  localparam logic [30:0] ACC_LIMIT  = 31'h10000;
  localparam logic [RMS_W-1:0] ROOT_OF_ONE = 24'd181;
  localparam logic [16:0] THR_RESET  = 17'd256;
  localparam logic [16:0] THR_MAX    = 17'h1FFFF;
  localparam logic [39:0] HANG_RESET = 40'd500000000;
  localparam logic [15:0] CAL_MIN    = 16'd5;
  localparam logic [15:0] CAL_LIMIT  = 16'hFFFF;
  localparam logic [47:0] DUR_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [5:0]  Q15_SHIFT  = 6'd15;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_CALIBRATE = 2'd1;
  localparam logic [1:0] CFG_HANGOVER  = 2'd2;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_START = 2'd1;
  localparam logic [1:0] EVT_STOP  = 2'd2;

  localparam logic [14:0] SQRT_FRAC [SQRT_TAB_SIZE] = '{
    15'd0, 15'd508, 15'd1008, 15'd1501, 15'd1987, 15'd2467, 15'd2940, 15'd3406,
    15'd3867, 15'd4322, 15'd4772, 15'd5216, 15'd5655, 15'd6090, 15'd6519, 15'd6944,
    15'd7364, 15'd7780, 15'd8191, 15'd8599, 15'd9003, 15'd9402, 15'd9798, 15'd10191,
    15'd10579, 15'd10965, 15'd11347, 15'd11725, 15'd12101, 15'd12473, 15'd12843,
    15'd13209, 15'd13572, 15'd13933, 15'd14291, 15'd14646, 15'd14999, 15'd15349,
    15'd15696, 15'd16041, 15'd16384, 15'd16724, 15'd17061, 15'd17397, 15'd17730,
    15'd18062, 15'd18391, 15'd18717, 15'd19042, 15'd19365, 15'd19686, 15'd20005,
    15'd20322, 15'd20637, 15'd20950, 15'd21261, 15'd21571, 15'd21879, 15'd22185,
    15'd22490, 15'd22792, 15'd23093, 15'd23393, 15'd23691, 15'd23987, 15'd24282,
    15'd24576, 15'd24867, 15'd25158, 15'd25447, 15'd25734, 15'd26020, 15'd26305,
    15'd26588, 15'd26870, 15'd27151, 15'd27430, 15'd27708, 15'd27985, 15'd28261,
    15'd28535, 15'd28808, 15'd29080, 15'd29350, 15'd29620, 15'd29888, 15'd30155,
    15'd30422, 15'd30686, 15'd30950, 15'd31213, 15'd31475, 15'd31735, 15'd31995,
    15'd32253, 15'd32511
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_BUF, ST_CAL_D1, ST_CAL_W1, ST_CAL_D2, ST_CAL_W2, ST_CAL_MUL,
    ST_CAL_FIN, ST_SQ, ST_ACC, ST_NORM, ST_PDIV, ST_PWAIT, ST_POWER, ST_ROOT1,
    ST_ROOT2, ST_ROOT3, ST_RSQ, ST_UPD, ST_EMIT
  } st_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_BUFSTART, OP_DIV_MEAN, OP_DIV_SQM, OP_CAL_MUL, OP_CAL_FIN,
    OP_SQ, OP_ACC, OP_NORM, OP_COUNT, OP_PDIV, OP_POWER, OP_ROOT1, OP_ROOT2,
    OP_ROOT3, OP_RMS_SQ, OP_UPDATE, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic acc_big;
    logic frame_last;
    logic cal_due;
    logic div_busy;
    logic out_free;
  } status_t;

  // highest set bit among bits 31..1, zero if none
  function automatic logic [4:0] top_bit(input logic [31:0] x);
    logic [4:0] b;
    b = 5'd0;
    for (int k = 1; k < 32; k++) begin
      if (x[k]) b = 5'(k);
    end
    return b;
  endfunction

  function automatic logic [VOTE_W-1:0] ones(input logic [WINDOW_FRAMES-1:0] v);
    logic [VOTE_W-1:0] c;
    c = '0;
    for (int k = 0; k < WINDOW_FRAMES; k++) begin
      c = c + VOTE_W'(v[k]);
    end
    return c;
  endfunction

endpackage

// ----- design/energy_voice_activity_detector_core.sv -----
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_core
// frame-energy speech detector with calibration, voting and hangover
// ----------------------------------------------------------------------------
// usage:
//   in_*   : one audio sample per item; in_tlast marks a frame end, in_tuser
//            marks a buffer end, in_tdata also carries the buffer duration
//   out_*  : one item per finished frame (rms, votes, speech flag, event,
//            calibration flag); samples that do not end a frame give none
//   cfg_*  : register writes (threshold, calibrate, hangover), only while idle
// processing:
//   a sample that does not end a frame is squared and added to the power
//   accumulator, which is halved while too large; a frame end adds a power
//   division in the bit-serial 48-bit divider and the three-step square root;
//   the first sample of a buffer that completes a calibration adds the two
//   divisions of the threshold estimate
// reset:
//   rst_n is synchronous, active low; threshold 256, silence, empty window
// stall:
//   a result waits in the output register; the next sample is still taken,
//   but its frame evaluation holds before loading until out_tready frees it
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // sample[15:0], buffer_duration[55:16]
  input  logic        in_tlast,   // frame_end
  input  logic        in_tuser,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // frame_rms[15:0], vote_count[22:16],
                                  // speech_active[23], transition_event[25:24],
                                  // calibrating[26], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_wdata
);
  import evad_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  evad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and detector state
  evad_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_sample     (in_tdata[15:0]),
    .in_frame_end  (in_tlast),
    .in_buffer_end (in_tuser),
    .in_duration   (in_tdata[55:16]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

// ----- design/evad_div.sv -----
// ----------------------------------------------------------------------------
// evad_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module evad_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [evad_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      busy,
  output logic [evad_pkg::DIV_W-1:0] quotient
);
  import evad_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     dq_r;
  logic [15:0]          rem_r;
  logic [15:0]          dvs_r;
  logic [16:0]          trial;
  logic                 ge;

  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
      dq_r  <= {dq_r[DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

// ----- design/evad_ctrl.sv -----
// ----------------------------------------------------------------------------
// evad_ctrl
// sequencer for per-sample accumulation and per-frame evaluation
// ----------------------------------------------------------------------------
module evad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  evad_pkg::status_t status,
  output evad_pkg::cmd_t    cmd
);
  import evad_pkg::*;

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_BUF;
      ST_BUF:     state_nxt = status.cal_due ? ST_CAL_D1 : ST_SQ;
      ST_CAL_D1:  state_nxt = ST_CAL_W1;
      ST_CAL_W1:  if (!status.div_busy) state_nxt = ST_CAL_D2;
      ST_CAL_D2:  state_nxt = ST_CAL_W2;
      ST_CAL_W2:  if (!status.div_busy) state_nxt = ST_CAL_MUL;
      ST_CAL_MUL: state_nxt = ST_CAL_FIN;
      ST_CAL_FIN: state_nxt = ST_SQ;
      ST_SQ:      state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_NORM;
      ST_NORM: begin
        if (!status.acc_big) state_nxt = status.frame_last ? ST_PDIV : ST_IDLE;
      end
      ST_PDIV:    state_nxt = ST_PWAIT;
      ST_PWAIT:   if (!status.div_busy) state_nxt = ST_POWER;
      ST_POWER:   state_nxt = ST_ROOT1;
      ST_ROOT1:   state_nxt = ST_ROOT2;
      ST_ROOT2:   state_nxt = ST_ROOT3;
      ST_ROOT3:   state_nxt = ST_RSQ;
      ST_RSQ:     state_nxt = ST_UPD;
      ST_UPD:     state_nxt = ST_EMIT;
      ST_EMIT:    if (status.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      ST_BUF:     cmd.op = OP_BUFSTART;
      ST_CAL_D1:  cmd.op = OP_DIV_MEAN;
      ST_CAL_D2:  cmd.op = OP_DIV_SQM;
      ST_CAL_MUL: cmd.op = OP_CAL_MUL;
      ST_CAL_FIN: cmd.op = OP_CAL_FIN;
      ST_SQ:      cmd.op = OP_SQ;
      ST_ACC:     cmd.op = OP_ACC;
      ST_NORM:    cmd.op = status.acc_big ? OP_NORM : OP_COUNT;
      ST_PDIV:    cmd.op = OP_PDIV;
      ST_POWER:   cmd.op = OP_POWER;
      ST_ROOT1:   cmd.op = OP_ROOT1;
      ST_ROOT2:   cmd.op = OP_ROOT2;
      ST_ROOT3:   cmd.op = OP_ROOT3;
      ST_RSQ:     cmd.op = OP_RMS_SQ;
      ST_UPD:     cmd.op = OP_UPDATE;
      ST_EMIT:    if (status.out_free) cmd.op = OP_EMIT;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- design/evad_dp.sv -----
// ----------------------------------------------------------------------------
// evad_dp
// datapath: power accumulator, divider, square root, calibration and voting
// ----------------------------------------------------------------------------
module evad_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  evad_pkg::cmd_t    cmd,
  output evad_pkg::status_t status,
  input  logic [15:0]       in_sample,
  input  logic              in_frame_end,
  input  logic              in_buffer_end,
  input  logic [39:0]       in_duration,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [39:0]       cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);
  import evad_pkg::*;

  // item and frame working registers
  logic signed [15:0] smp_r;
  logic               fr_end_r, buf_end_r;
  logic [39:0]        dur_r;
  logic [30:0]        sq_r, acc_r;
  logic [5:0]         shift_r;
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        power_r;
  logic [4:0]         lg_r;
  logic               xz_r, xo_r;
  logic [6:0]         idx_r;
  logic [RMS_W-1:0]   rms_r;
  logic [47:0]        rms_sq_r;
  logic [RMS_W-1:0]   mean_r;
  logic [47:0]        sqm_r, mm_r;

  // detector state
  logic [WINDOW_FRAMES-1:0] win_r;
  logic [47:0]        silent_dur_r;
  logic               is_silent_r, was_silent_r, calib_r, in_buffer_r;
  logic [16:0]        active_thr_r;
  logic [47:0]        rms_sum_r, rms_sq_sum_r;
  logic [15:0]        cal_frames_r;
  logic [39:0]        hang_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  // divider
  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_dvd, div_q;
  logic [15:0]        div_dvs;
  logic [5:0]         up_sh;

  assign up_sh     = shift_r - Q15_SHIFT;
  assign div_start = (cmd.op == OP_DIV_MEAN) || (cmd.op == OP_DIV_SQM) ||
                     (cmd.op == OP_PDIV);

  always_comb begin
    div_dvd = rms_sum_r;
    div_dvs = cal_frames_r;
    case (cmd.op)
      OP_DIV_SQM: div_dvd = rms_sq_sum_r;
      OP_PDIV: begin
        div_dvs = 16'(count_r);
        if (shift_r > Q15_SHIFT) div_dvd = DIV_W'(acc_r[16:0]) << up_sh[4:0];
        else                     div_dvd = DIV_W'(acc_r[16:0]);
      end
      default: div_dvd = rms_sum_r;
    endcase
  end

  evad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // power from quotient
  logic [31:0] power_nxt;
  assign power_nxt = (shift_r > Q15_SHIFT) ? div_q[31:0]
                                           : 32'(div_q >> (Q15_SHIFT - shift_r));

  // root stage 1: odd exponent
  logic [4:0] tb_pow, lg_nxt;
  assign tb_pow = top_bit(power_r);
  assign lg_nxt = tb_pow[0] ? tb_pow : tb_pow - 5'd1;

  // root stage 2: table index
  logic [31:0] idx_full;
  logic [36:0] idx_scaled;
  assign idx_full   = power_r - (32'd1 << lg_r);
  assign idx_scaled = {idx_full, 5'd0} >> lg_r;

  // root stage 3: interpolation
  logic [4:0]        base_sh;
  logic [RMS_W-1:0]  base;
  logic [37:0]       frac_term;
  logic [RMS_W-1:0]  root_val;
  assign base_sh   = 5'd8 + {1'b0, lg_r[4:1]};
  assign base      = RMS_W'(1) << base_sh;
  assign frac_term = (38'(SQRT_FRAC[idx_r]) << base_sh) >> 15;
  assign root_val  = xz_r ? '0 : (xo_r ? ROOT_OF_ONE : base + frac_term[RMS_W-1:0]);

  // threshold estimate
  logic [47:0] var_val;
  logic [4:0]  tb_var;
  logic [16:0] dev;
  logic [25:0] th_sum;
  assign var_val = (sqm_r > mm_r) ? sqm_r - mm_r : '0;
  assign tb_var  = top_bit(var_val[31:0]);
  assign dev     = 17'd1 << (tb_var[4:1] + 4'd1);
  assign th_sum  = 26'(mean_r) + 26'(dev) * 26'd3;

  // vote and hangover
  logic                     vbit, majority, trip;
  logic [WINDOW_FRAMES-1:0] win_nxt;
  logic [48:0]              sd_sum;
  logic [47:0]              sd_sat, sd_nxt;
  assign vbit     = rms_r > RMS_W'(active_thr_r);
  assign win_nxt  = (win_r >> 1) | (WINDOW_FRAMES'(vbit) << (WINDOW_FRAMES - 1));
  assign majority = ones(win_nxt) > VOTE_W'(WINDOW_FRAMES / 2);
  assign sd_sum   = {1'b0, silent_dur_r} + 49'(dur_r);
  assign sd_sat   = sd_sum[48] ? DUR_MAX : sd_sum[47:0];
  assign sd_nxt   = majority ? '0 : sd_sat;
  assign trip     = sd_nxt > 48'(hang_r);

  logic [1:0] evt;
  always_comb begin
    evt = EVT_NONE;
    if (buf_end_r && (is_silent_r != was_silent_r)) evt = is_silent_r ? EVT_STOP : EVT_START;
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  assign status.acc_big    = acc_r > ACC_LIMIT;
  assign status.frame_last = fr_end_r || buf_end_r ||
                             (({1'b0, count_r} + 1'b1) >= (CNT_W + 1)'(FRAME_SAMPLES));
  assign status.cal_due    = !in_buffer_r && calib_r && (cal_frames_r > CAL_MIN);
  assign status.div_busy   = div_busy;
  assign status.out_free   = out_free;

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        smp_r     <= signed'(in_sample);
        fr_end_r  <= in_frame_end;
        buf_end_r <= in_buffer_end;
        dur_r     <= in_duration;
      end
      OP_DIV_SQM: mean_r <= div_q[RMS_W-1:0];
      OP_CAL_MUL: begin
        sqm_r <= div_q;
        mm_r  <= mean_r * mean_r;
      end
      OP_SQ:     sq_r <= 31'(smp_r * smp_r);
      OP_POWER:  power_r <= power_nxt;
      OP_ROOT1: begin
        lg_r <= lg_nxt;
        xz_r <= power_r == 32'd0;
        xo_r <= power_r == 32'd1;
      end
      OP_ROOT2:  idx_r <= (idx_scaled > 37'(SQRT_TAB_SIZE - 1)) ? 7'(SQRT_TAB_SIZE - 1)
                                                                  : idx_scaled[6:0];
      OP_ROOT3:  rms_r <= root_val;
      OP_RMS_SQ: rms_sq_r <= rms_r * rms_r;
      OP_EMIT:   out_data_r <= {5'd0, calib_r, evt, ~is_silent_r,
                                7'(ones(win_r)), rms_r[15:0]};
      default: ;
    endcase
  end

  // control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      shift_r      <= '0;
      count_r      <= '0;
      win_r        <= '0;
      silent_dur_r <= '0;
      is_silent_r  <= 1'b1;
      was_silent_r <= 1'b1;
      active_thr_r <= THR_RESET;
      rms_sum_r    <= '0;
      rms_sq_sum_r <= '0;
      cal_frames_r <= '0;
      calib_r      <= 1'b0;
      in_buffer_r  <= 1'b0;
      hang_r       <= HANG_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_BUFSTART: begin
          if (!in_buffer_r) begin
            in_buffer_r  <= 1'b1;
            was_silent_r <= is_silent_r;
          end
        end
        OP_CAL_FIN: begin
          active_thr_r <= (th_sum > 26'(THR_MAX)) ? THR_MAX : th_sum[16:0];
          calib_r      <= 1'b0;
        end
        OP_ACC:   if (shift_r < 6'd32) acc_r <= acc_r + (sq_r >> shift_r);
        OP_NORM: begin
          acc_r   <= acc_r >> 1;
          shift_r <= shift_r + 6'd1;
        end
        OP_COUNT: count_r <= count_r + 1'b1;
        OP_UPDATE: begin
          if (calib_r) begin
            if (cal_frames_r != CAL_LIMIT) begin
              rms_sum_r    <= rms_sum_r + 48'(rms_r);
              rms_sq_sum_r <= rms_sq_sum_r + rms_sq_r;
              cal_frames_r <= cal_frames_r + 16'd1;
            end
          end else begin
            win_r        <= win_nxt;
            silent_dur_r <= sd_nxt;
            if (majority) is_silent_r <= 1'b0;
            if (trip)     is_silent_r <= 1'b1;
          end
        end
        OP_EMIT: begin
          out_valid_r <= 1'b1;
          acc_r       <= '0;
          shift_r     <= '0;
          count_r     <= '0;
          if (buf_end_r) in_buffer_r <= 1'b0;
        end
        default: ;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: begin
            active_thr_r <= {2'b00, cfg_wdata[14:0]};
            calib_r      <= 1'b0;
          end
          CFG_CALIBRATE: begin
            if (cfg_wdata[0]) begin
              is_silent_r  <= 1'b1;
              calib_r      <= 1'b1;
              win_r        <= '0;
              rms_sum_r    <= '0;
              rms_sq_sum_r <= '0;
              cal_frames_r <= '0;
            end
          end
          CFG_HANGOVER: hang_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");

  // the divider is never restarted while it runs
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a finished frame leaves a cleared accumulator
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |=> (count_r == '0 && shift_r == '0 && acc_r == '0))
    else $error("frame accumulator not cleared");

endmodule
